FILE: hw/rtl/idrr_pkg.sv
`timescale 1ns / 1ps
package idrr_pkg;

  // Result kinds as they appear on the output channel.
  typedef enum logic [3:0] {
    KIND_IGNORED   = 4'd0,
    KIND_PROGRESS  = 4'd1,
    KIND_FLOW_CTRL = 4'd2,
    KIND_NEGATIVE  = 4'd3,
    KIND_SEQ_ERROR = 4'd4,
    KIND_OVERFLOW  = 4'd5,
    KIND_HEADER    = 4'd6,
    KIND_DTC       = 4'd7,
    KIND_OTHER     = 4'd8
  } kind_t;

  // Protocol control information, upper nibble of the first data byte.
  localparam logic [3:0] PCI_SF = 4'h0;
  localparam logic [3:0] PCI_FF = 4'h1;
  localparam logic [3:0] PCI_CF = 4'h2;

  localparam logic [7:0] SID_NEGATIVE = 8'h7F;
  localparam logic [7:0] SID_READ_DTC = 8'h59;

  localparam logic [3:0]  FRAME_MAX_LEN = 4'd8;
  localparam logic [11:0] FF_MIN_TOTAL  = 12'd8;

  localparam logic [28:0] RESPONSE_ID_RST = 29'h18DAF110;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_ID    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECEIVE_ENABLE = 1'b1;

  typedef struct packed {
    logic [28:0]     can_id;
    logic [3:0]      flen;
    logic [7:0][7:0] d;
  } frame_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  service;
    logic [7:0]  info;
    logic [7:0]  mask;
    logic [23:0] dtc;
    logic [6:0]  mlen;
    logic        last;
  } result_t;

  localparam result_t RES_IGNORED = '{KIND_IGNORED, 8'h00, 8'h00, 8'h00, 24'h0, 7'h0, 1'b1};

endpackage

FILE: hw/rtl/idrr_store.sv
`timescale 1ns / 1ps
module idrr_store #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [7:0]               rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/idrr_outreg.sv
`timescale 1ns / 1ps
module idrr_outreg import idrr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  output logic    push_ready,
  input  result_t din,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t dout
);

  logic    valid_r;
  logic    valid_nxt;
  result_t data_r;
  result_t data_nxt;

  // A new result may load when the register is empty, or when the held one leaves in the same cycle.
  assign push_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (push && push_ready) begin
      valid_nxt = 1'b1;
      data_nxt  = din;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign out_valid = valid_r;
  assign dout      = data_r;

endmodule

FILE: hw/rtl/idrr_ctrl.sv
`timescale 1ns / 1ps
module idrr_ctrl import idrr_pkg::*; #(
  parameter int PAYLOAD_BYTES = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [28:0]                      response_id,
  input  logic                             receive_enable,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  frame_t                           in_frame,
  output logic                             wr_en,
  output logic [$clog2(PAYLOAD_BYTES)-1:0] wr_addr,
  output logic [7:0]                       wr_data,
  output logic                             rd_en,
  output logic [$clog2(PAYLOAD_BYTES)-1:0] rd_addr,
  input  logic [7:0]                       rd_data,
  output logic                             res_valid,
  input  logic                             res_ready,
  output result_t                          res
);

  localparam int ADDR_W = $clog2(PAYLOAD_BYTES);
  localparam int CNT_W  = $clog2(PAYLOAD_BYTES + 1);
  localparam logic [12:0] PB_P1 = 13'(PAYLOAD_BYTES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WRITE,
    S_REPORT,
    S_READ,
    S_BUILD,
    S_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  frame_t              frame_r, frame_nxt;
  logic [CNT_W-1:0]    rcv_r, rcv_nxt;
  logic [CNT_W-1:0]    exp_r, exp_nxt;
  logic [3:0]          seq_r, seq_nxt;
  logic                in_msg_r, in_msg_nxt;
  logic [7:0]          svc_r, svc_nxt;
  logic [2:0]          wr_left_r, wr_left_nxt;
  logic [2:0]          wr_src_r, wr_src_nxt;
  logic [ADDR_W-1:0]   wr_addr_r, wr_addr_nxt;
  logic                cmpl_r, cmpl_nxt;
  result_t             res_r, res_nxt;
  logic [CNT_W-1:0]    rd_base_r, rd_base_nxt;
  logic [2:0]          rd_k_r, rd_k_nxt;
  logic [2:0]          rd_num_r, rd_num_nxt;
  logic                is_hdr_r, is_hdr_nxt;
  logic [3:0]          rec_left_r, rec_left_nxt;
  logic                pend_r, pend_nxt;
  logic [1:0]          pend_pos_r, pend_pos_nxt;
  logic                pend_ok_r, pend_ok_nxt;
  logic [3:0][7:0]     rec_b_r, rec_b_nxt;

  logic [3:0]          nib;
  logic [3:0]          low;
  logic                id_hit;
  logic                sf_bad;
  logic [11:0]         total;
  logic                ff_short;
  logic                ff_over;
  logic [2:0]          n_raw;
  logic [CNT_W-1:0]    room;
  logic [2:0]          n_take;
  logic [CNT_W-1:0]    rcv_after;
  logic [CNT_W-1:0]    quads;
  logic [3:0]          nrec;
  logic [CNT_W-1:0]    rd_pos;

  assign nib    = frame_r.d[0][7:4];
  assign low    = frame_r.d[0][3:0];
  assign id_hit = receive_enable && (frame_r.can_id == response_id);
  assign sf_bad = (low == 4'd0) || (low > 4'd7) ||
                  ({1'b0, frame_r.flen} < ({1'b0, low} + 5'd1));
  assign total    = {low, frame_r.d[1]};
  assign ff_short = (frame_r.flen != FRAME_MAX_LEN) || (total < FF_MIN_TOTAL);
  assign ff_over  = ({1'b0, total} > PB_P1);

  // Consecutive frame: data bytes carried, limited to what is still owed.
  assign n_raw     = (frame_r.flen == 4'd0) ? 3'd0 : 3'(frame_r.flen - 4'd1);
  assign room      = (exp_r > rcv_r) ? (exp_r - rcv_r) : '0;
  assign n_take    = (room < CNT_W'(n_raw)) ? 3'(room) : n_raw;
  assign rcv_after = rcv_r + CNT_W'(n_take);

  // Records of four bytes after the two header bytes, at most fifteen.
  assign quads = (rcv_r - CNT_W'(2)) >> 2;
  assign nrec  = (rcv_r < CNT_W'(6)) ? 4'd0 :
                 ((quads > CNT_W'(15)) ? 4'd15 : 4'(quads));

  assign rd_pos = rd_base_r + CNT_W'(rd_k_r);

  always_comb begin
    state_nxt    = state_r;
    frame_nxt    = frame_r;
    rcv_nxt      = rcv_r;
    exp_nxt      = exp_r;
    seq_nxt      = seq_r;
    in_msg_nxt   = in_msg_r;
    svc_nxt      = svc_r;
    wr_left_nxt  = wr_left_r;
    wr_src_nxt   = wr_src_r;
    wr_addr_nxt  = wr_addr_r;
    cmpl_nxt     = cmpl_r;
    res_nxt      = res_r;
    rd_base_nxt  = rd_base_r;
    rd_k_nxt     = rd_k_r;
    rd_num_nxt   = rd_num_r;
    is_hdr_nxt   = is_hdr_r;
    rec_left_nxt = rec_left_r;
    pend_nxt     = 1'b0;
    pend_pos_nxt = pend_pos_r;
    pend_ok_nxt  = pend_ok_r;
    rec_b_nxt    = rec_b_r;
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = wr_addr_r;
    wr_data      = frame_r.d[wr_src_r];
    rd_en        = 1'b0;
    rd_addr      = rd_pos[ADDR_W-1:0];

    // Read data lands in the cycle after the address; bytes past the message read as zero.
    if (pend_r) begin
      rec_b_nxt[pend_pos_r] = pend_ok_r ? rd_data : 8'h00;
    end

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          frame_nxt = in_frame;
          if (in_frame.flen > FRAME_MAX_LEN) begin
            frame_nxt.flen = FRAME_MAX_LEN;
          end
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        res_nxt   = RES_IGNORED;
        state_nxt = S_EMIT;
        if (id_hit) begin
          unique case (nib)
            PCI_SF: begin
              if (!sf_bad) begin
                in_msg_nxt = 1'b0;
                if (frame_r.d[1] == SID_NEGATIVE) begin
                  res_nxt.kind    = KIND_NEGATIVE;
                  res_nxt.service = frame_r.d[2];
                  res_nxt.info    = frame_r.d[3];
                end else begin
                  svc_nxt     = frame_r.d[1];
                  rcv_nxt     = CNT_W'(low - 4'd1);
                  exp_nxt     = CNT_W'(low - 4'd1);
                  wr_left_nxt = 3'(low - 4'd1);
                  wr_src_nxt  = 3'd2;
                  wr_addr_nxt = '0;
                  cmpl_nxt    = 1'b1;
                  state_nxt   = S_WRITE;
                end
              end
            end
            PCI_FF: begin
              if (!ff_short) begin
                if (ff_over) begin
                  in_msg_nxt      = 1'b0;
                  res_nxt.kind    = KIND_OVERFLOW;
                  res_nxt.service = frame_r.d[2];
                end else begin
                  svc_nxt         = frame_r.d[2];
                  rcv_nxt         = CNT_W'(5);
                  exp_nxt         = CNT_W'(total - 12'd1);
                  seq_nxt         = 4'd1;
                  in_msg_nxt      = 1'b1;
                  wr_left_nxt     = 3'd5;
                  wr_src_nxt      = 3'd3;
                  wr_addr_nxt     = '0;
                  cmpl_nxt        = 1'b0;
                  res_nxt.kind    = KIND_FLOW_CTRL;
                  res_nxt.service = frame_r.d[2];
                  state_nxt       = S_WRITE;
                end
              end
            end
            PCI_CF: begin
              if (in_msg_r) begin
                if (low != seq_r) begin
                  in_msg_nxt      = 1'b0;
                  res_nxt.kind    = KIND_SEQ_ERROR;
                  res_nxt.service = svc_r;
                end else begin
                  wr_left_nxt     = n_take;
                  wr_src_nxt      = 3'd1;
                  wr_addr_nxt     = rcv_r[ADDR_W-1:0];
                  rcv_nxt         = rcv_after;
                  seq_nxt         = seq_r + 4'd1;
                  cmpl_nxt        = (rcv_after >= exp_r);
                  res_nxt.kind    = KIND_PROGRESS;
                  res_nxt.service = svc_r;
                  state_nxt       = S_WRITE;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_WRITE: begin
        if (wr_left_r != 3'd0) begin
          wr_en       = 1'b1;
          wr_left_nxt = wr_left_r - 3'd1;
          wr_src_nxt  = wr_src_r + 3'd1;
          wr_addr_nxt = wr_addr_r + ADDR_W'(1);
        end else begin
          state_nxt = cmpl_r ? S_REPORT : S_EMIT;
        end
      end

      S_REPORT: begin
        in_msg_nxt = 1'b0;
        if (svc_r == SID_READ_DTC) begin
          rd_base_nxt  = '0;
          rd_k_nxt     = 3'd0;
          rd_num_nxt   = 3'd2;
          is_hdr_nxt   = 1'b1;
          rec_left_nxt = nrec;
          state_nxt    = S_READ;
        end else begin
          res_nxt         = RES_IGNORED;
          res_nxt.kind    = KIND_OTHER;
          res_nxt.service = svc_r;
          res_nxt.mlen    = 7'(rcv_r);
          state_nxt       = S_EMIT;
        end
      end

      S_READ: begin
        if (rd_k_r < rd_num_r) begin
          rd_en        = 1'b1;
          pend_nxt     = 1'b1;
          pend_pos_nxt = rd_k_r[1:0];
          pend_ok_nxt  = (rd_pos < rcv_r);
          rd_k_nxt     = rd_k_r + 3'd1;
        end else begin
          state_nxt = S_BUILD;
        end
      end

      S_BUILD: begin
        res_nxt         = RES_IGNORED;
        res_nxt.service = SID_READ_DTC;
        res_nxt.mlen    = 7'(rcv_r);
        rd_k_nxt        = 3'd0;
        rd_num_nxt      = 3'd4;
        is_hdr_nxt      = 1'b0;
        if (is_hdr_r) begin
          res_nxt.kind = KIND_HEADER;
          res_nxt.info = rec_b_r[0];
          res_nxt.mask = rec_b_r[1];
          res_nxt.last = (rec_left_r == 4'd0);
          rd_base_nxt  = CNT_W'(2);
        end else begin
          res_nxt.kind = KIND_DTC;
          res_nxt.mask = rec_b_r[3];
          res_nxt.dtc  = {rec_b_r[0], rec_b_r[1], rec_b_r[2]};
          res_nxt.last = (rec_left_r == 4'd1);
          rec_left_nxt = rec_left_r - 4'd1;
          rd_base_nxt  = rd_base_r + CNT_W'(4);
        end
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = res_r.last ? S_IDLE : S_READ;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    frame_r    <= frame_nxt;
    wr_left_r  <= wr_left_nxt;
    wr_src_r   <= wr_src_nxt;
    wr_addr_r  <= wr_addr_nxt;
    cmpl_r     <= cmpl_nxt;
    res_r      <= res_nxt;
    rd_base_r  <= rd_base_nxt;
    rd_k_r     <= rd_k_nxt;
    rd_num_r   <= rd_num_nxt;
    is_hdr_r   <= is_hdr_nxt;
    rec_left_r <= rec_left_nxt;
    pend_pos_r <= pend_pos_nxt;
    pend_ok_r  <= pend_ok_nxt;
    rec_b_r    <= rec_b_nxt;
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rcv_r    <= '0;
      exp_r    <= '0;
      seq_r    <= 4'd1;
      in_msg_r <= 1'b0;
      svc_r    <= 8'h00;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rcv_r    <= rcv_nxt;
      exp_r    <= exp_nxt;
      seq_r    <= seq_nxt;
      in_msg_r <= in_msg_nxt;
      svc_r    <= svc_nxt;
      pend_r   <= pend_nxt;
    end
  end

  assign res = res_r;

endmodule

FILE: hw/rtl/isotp_dtc_report_reassembler_top.sv
`timescale 1ns / 1ps
// Reassembles ISO-TP responses from one ECU and turns diagnostic trouble code
// reports into one item per record.
// The input channel (in_*) takes one received CAN frame per item. The output
// channel (out_*) gives one or more result items per frame; out_tlast marks
// the final result of a frame. The configuration port writes the response
// identifier (index 0) and the receive enable (index 1); the user must
// write them only while idle, which the block itself does not enforce.
// Each frame is handled on its own: it is accepted, decoded, and its data
// bytes are written into the payload store one byte per cycle. A frame that
// completes a report then reads the store back through its single read port,
// one byte per cycle within each item: two for the header, four for each of
// at most 15 records.
// The next frame is accepted once the last result of the current one has
// been loaded into the output register, so one result may still wait there.
// If the receiver stalls, the block holds its pending result and takes no new
// frame until the output register frees up; nothing is dropped.
// Reset clears the control state and loads the register reset values; the
// payload store needs no clearing, since only bytes written by the current
// message are read back.
module isotp_dtc_report_reassembler_top import idrr_pkg::*; #(
  parameter int PAYLOAD_BYTES = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [28:0]          cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // can_id[28:0], frame_len[32:29], data_byte_0 .. data_byte_7 from bit 33
  // upward, eight bits each, zero fill [103:97]
  input  logic [103:0]         in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // service_id[7:0], info_byte[15:8], mask_or_status[23:16], dtc_code[47:24],
  // message_length[54:48], zero fill [55]
  output logic [55:0]          out_tdata,
  // result_kind[3:0]
  output logic [3:0]           out_tuser,
  output logic                 out_tlast
);

  localparam int ADDR_W = $clog2(PAYLOAD_BYTES);

  logic [28:0]       response_id_r;
  logic              receive_enable_r;
  frame_t            in_frame;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              res_valid;
  logic              res_ready;
  result_t           res;
  result_t           out_res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      response_id_r    <= RESPONSE_ID_RST;
      receive_enable_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RESPONSE_ID:    response_id_r    <= cfg_wdata;
        CFG_RECEIVE_ENABLE: receive_enable_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Unpack the frame item.
  always_comb begin
    in_frame.can_id = in_tdata[28:0];
    in_frame.flen   = in_tdata[32:29];
    for (int k = 0; k < 8; k++) begin
      in_frame.d[k] = in_tdata[33 + 8 * k +: 8];
    end
  end

  idrr_ctrl #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .response_id    (response_id_r),
    .receive_enable (receive_enable_r),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_frame       (in_frame),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res)
  );

  // The controller never reads and writes in the same cycle, so a read
  // always sees every byte written before it.
  idrr_store #(
    .DEPTH (PAYLOAD_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  idrr_outreg u_outreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_ready (res_ready),
    .din        (res),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .dout       (out_res)
  );

  assign out_tdata = {1'b0, out_res.mlen, out_res.dtc, out_res.mask,
                      out_res.info, out_res.service};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule

FILE: hw/rtl/idrr_checker.sv
`timescale 1ns / 1ps
module idrr_checker import idrr_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [3:0]  out_tuser,
  input logic        out_tlast
);

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // Frames are taken one at a time.
  a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("frame accepted while the previous one is in work");

  // Every kind but header and record ends its frame.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_HEADER && out_tuser != KIND_DTC |-> out_tlast)
    else $error("single result without last");

  // Report items always carry the DTC service.
  a_report_svc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_HEADER || out_tuser == KIND_DTC) |->
      out_tdata[7:0] == SID_READ_DTC)
    else $error("report item with wrong service");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind isotp_dtc_report_reassembler_top idrr_checker u_idrr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

FILE: tb/isotp_report_checker.sv
`timescale 1ns / 1ps
module isotp_report_checker import idrr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [28:0]          cfg_wdata,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  // can_id[28:0], frame_len[32:29], data_byte_0 .. data_byte_7 from bit 33 up
  input  logic [103:0]         in_tdata,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  // service_id[7:0], info_byte[15:8], mask_or_status[23:16], dtc_code[47:24],
  // message_length[54:48]
  input  logic [55:0]          out_tdata,
  // result_kind[3:0]
  input  logic [3:0]           out_tuser,
  input  logic                 out_tlast,
  output int                   error_count,
  output int                   results_outstanding
);

  localparam int STORE_BYTES = 64;
  localparam int MAX_RECORDS = 15;

  // Shadow copy of the registers and of the reassembly state.
  logic [28:0] match_id;
  logic        rx_enabled;
  logic [7:0]  store [STORE_BYTES];
  int          rcvd_bytes;
  int          want_bytes;
  logic [3:0]  seq_next;
  logic        msg_open;
  logic [7:0]  msg_service;

  result_t expected_results[$];
  result_t frame_results[$];

  function automatic result_t make_result(kind_t k, logic [7:0] svc, logic [7:0] info,
                                          logic [7:0] mask, logic [23:0] code,
                                          logic [6:0] len);
    result_t r;
    r.kind    = k;
    r.service = svc;
    r.info    = info;
    r.mask    = mask;
    r.dtc     = code;
    r.mlen    = len;
    r.last    = 1'b0;
    return r;
  endfunction

  // Bytes past the end of the message read as zero.
  function automatic logic [7:0] stored_byte(int idx);
    if (idx >= rcvd_bytes) return 8'h00;
    return store[idx];
  endfunction

  // A finished message gives a report header plus its records, or one summary.
  task automatic close_message();
    int idx;
    int recs;
    if (msg_service == SID_READ_DTC) begin
      frame_results.push_back(make_result(KIND_HEADER, SID_READ_DTC, stored_byte(0),
                                          stored_byte(1), 24'h0, 7'(rcvd_bytes)));
      recs = 0;
      for (idx = 2; idx + 4 <= rcvd_bytes && recs < MAX_RECORDS; idx += 4) begin
        frame_results.push_back(make_result(KIND_DTC, SID_READ_DTC, 8'h00,
            stored_byte(idx + 3),
            {stored_byte(idx), stored_byte(idx + 1), stored_byte(idx + 2)},
            7'(rcvd_bytes)));
        recs++;
      end
    end else begin
      frame_results.push_back(make_result(KIND_OTHER, msg_service, 8'h00, 8'h00, 24'h0,
                                          7'(rcvd_bytes)));
    end
    msg_open = 1'b0;
  endtask

  task automatic reassemble_frame(input logic [103:0] bits);
    logic [28:0] id;
    logic [7:0]  d [8];
    logic [3:0]  nib;
    int          flen;
    int          low;
    int          total;
    int          take;
    int          room;
    int          k;
    id   = bits[28:0];
    flen = bits[32:29];
    if (flen > 8) flen = 8;
    for (k = 0; k < 8; k++) d[k] = bits[33 + 8 * k +: 8];
    nib = d[0][7:4];
    low = d[0][3:0];
    frame_results.delete();
    if (!rx_enabled || id != match_id) begin
      frame_results.push_back(RES_IGNORED);
    end else if (nib == PCI_SF) begin
      if (low == 0 || low > 7 || flen < low + 1) begin
        frame_results.push_back(RES_IGNORED);
      end else begin
        msg_open = 1'b0;
        if (d[1] == SID_NEGATIVE) begin
          frame_results.push_back(make_result(KIND_NEGATIVE, d[2], d[3], 8'h00, 24'h0, 7'h0));
        end else begin
          msg_service = d[1];
          for (k = 0; k < low - 1; k++) store[k] = d[k + 2];
          rcvd_bytes = low - 1;
          want_bytes = low - 1;
          close_message();
        end
      end
    end else if (nib == PCI_FF) begin
      total = {d[0][3:0], d[1]};
      if (flen < FRAME_MAX_LEN || total < FF_MIN_TOTAL) begin
        frame_results.push_back(RES_IGNORED);
      end else if (total - 1 > STORE_BYTES) begin
        msg_open = 1'b0;
        frame_results.push_back(make_result(KIND_OVERFLOW, d[2], 8'h00, 8'h00, 24'h0, 7'h0));
      end else begin
        msg_service = d[2];
        for (k = 0; k < 5; k++) store[k] = d[k + 3];
        rcvd_bytes = 5;
        want_bytes = total - 1;
        seq_next   = 4'd1;
        msg_open   = 1'b1;
        frame_results.push_back(make_result(KIND_FLOW_CTRL, msg_service, 8'h00, 8'h00,
                                            24'h0, 7'h0));
      end
    end else if (nib == PCI_CF) begin
      if (!msg_open) begin
        frame_results.push_back(RES_IGNORED);
      end else if (low != seq_next) begin
        msg_open = 1'b0;
        frame_results.push_back(make_result(KIND_SEQ_ERROR, msg_service, 8'h00, 8'h00,
                                            24'h0, 7'h0));
      end else begin
        // Padding past the announced length is thrown away.
        take = flen > 0 ? flen - 1 : 0;
        room = want_bytes > rcvd_bytes ? want_bytes - rcvd_bytes : 0;
        if (take > room) take = room;
        for (k = 0; k < take; k++) begin
          store[rcvd_bytes] = d[k + 1];
          rcvd_bytes++;
        end
        seq_next = seq_next + 4'd1;
        if (rcvd_bytes >= want_bytes) begin
          close_message();
        end else begin
          frame_results.push_back(make_result(KIND_PROGRESS, msg_service, 8'h00, 8'h00,
                                              24'h0, 7'h0));
        end
      end
    end else begin
      frame_results.push_back(RES_IGNORED);
    end
    frame_results[frame_results.size() - 1].last = 1'b1;
    for (k = 0; k < frame_results.size(); k++) expected_results.push_back(frame_results[k]);
  endtask

  // Results are checked before new frames are predicted, so a result can
  // never be matched against an expectation pushed at the same edge.
  always @(posedge clk) begin : track
    result_t seen;
    result_t oldest;
    if (!rst_n) begin
      match_id    = RESPONSE_ID_RST;
      rx_enabled  = 1'b0;
      rcvd_bytes  = 0;
      want_bytes  = 0;
      seq_next    = 4'd1;
      msg_open    = 1'b0;
      msg_service = 8'h00;
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        seen = '{kind_t'(out_tuser), out_tdata[7:0], out_tdata[15:8], out_tdata[23:16],
                 out_tdata[47:24], out_tdata[54:48], out_tlast};
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: unexpected result kind %0d service %02h with no frame pending",
                     $realtime, seen.kind, seen.service);
        end else begin
          oldest = expected_results.pop_front();
          if (seen.kind !== oldest.kind || seen.service !== oldest.service ||
              seen.info !== oldest.info || seen.mask !== oldest.mask ||
              seen.dtc !== oldest.dtc || seen.mlen !== oldest.mlen ||
              seen.last !== oldest.last) begin
            error_count++;
            if (error_count <= 10)
              $display("%0t: result mismatch: expected kind %0d svc %02h info %02h ",
                       $realtime, oldest.kind, oldest.service, oldest.info,
                       "mask %02h dtc %06h len %0d last %0b, ", oldest.mask, oldest.dtc,
                       oldest.mlen, oldest.last,
                       "got kind %0d svc %02h info %02h ", seen.kind, seen.service,
                       seen.info,
                       "mask %02h dtc %06h len %0d last %0b", seen.mask, seen.dtc,
                       seen.mlen, seen.last);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_RESPONSE_ID) match_id = cfg_wdata;
        else if (cfg_index == CFG_RECEIVE_ENABLE) rx_enabled = cfg_wdata[0];
      end
      if (in_tvalid && in_tready) reassemble_frame(in_tdata);
    end
    results_outstanding = expected_results.size();
  end

endmodule

FILE: tb/isotp_dtc_report_reassembler_top_tb.sv
`timescale 1ns / 1ps
module isotp_dtc_report_reassembler_top_tb import idrr_pkg::*;;

  // This settle time is meant to be long enough for any stray result to show up
  // after the last expected one.
  localparam int SETTLE_CYCLES  = 150;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT    = 1000000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [28:0]          cfg_wdata;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [103:0]         in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [55:0]          out_tdata;
  logic [3:0]           out_tuser;
  logic                 out_tlast;

  int error_count;
  int results_outstanding;
  int cycle_count = 0;

  // Pacing controls shared by the sender and the receiver. When a fast flag
  // is set that side runs without idle cycles. Each bump of hold_req asks the
  // receiver for one long hold-off.
  bit fast_tx  = 1'b0;
  bit fast_rx  = 1'b0;
  int hold_req = 0;

  isotp_dtc_report_reassembler_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // The checker watches both channels and the register port, predicts every
  // result and compares. This module only makes traffic and gives the verdict.
  isotp_report_checker report_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_tvalid           (in_tvalid),
    .in_tready           (in_tready),
    .in_tdata            (in_tdata),
    .out_tvalid          (out_tvalid),
    .out_tready          (out_tready),
    .out_tdata           (out_tdata),
    .out_tuser           (out_tuser),
    .out_tlast           (out_tlast),
    .error_count         (error_count),
    .results_outstanding (results_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL isotp_dtc_report_reassembler_top");
      $finish;
    end
  end

  // Four data bytes given, the upper four random. Byte 0 lands in the low bits.
  function automatic logic [63:0] with_head(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [7:0] b3);
    return {$urandom(), b3, b2, b1, b0};
  endfunction

  // Offers one frame and returns at the edge where it was taken. tvalid stays
  // high when the next frame follows with no gap, so it is never dropped and
  // raised again within one time step.
  task automatic send_frame(input logic [28:0] id, input logic [3:0] flen,
                            input logic [63:0] bytes);
    int gap;
    gap = fast_tx ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {7'h0, bytes, flen, id};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // Both registers are written back to back with the enable held high.
  task automatic write_regs(input logic [28:0] id, input logic en);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RESPONSE_ID;
    cfg_wdata <= id;
    @(posedge clk);
    cfg_index <= CFG_RECEIVE_ENABLE;
    cfg_wdata <= {28'h0, en};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stop offering and wait until every predicted result has been taken. Every
  // frame gives at least one result, so an empty queue means the block is idle.
  // The outstanding count is read at the falling edge, away from its update.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (results_outstanding != 0);
    @(posedge clk);
  endtask

  // A random frame: any frame type, any length, and half the time some other
  // identifier. Flow control frames are favored among the unused types.
  task automatic send_noise(input logic [28:0] id);
    logic [63:0] b;
    b = {$urandom(), $urandom()};
    if ($urandom_range(0, 2) == 0) b[7:4] = 4'h3;
    send_frame($urandom_range(0, 1) ? id : 29'($urandom()), 4'($urandom_range(0, 15)), b);
  endtask

  // One well-formed message with random content: a single frame, or a first
  // frame followed by consecutive frames in order. Now and then a stray frame
  // is mixed in or the sequence number is broken, which ends the message.
  // Trickle messages carry at most two bytes per frame so the sequence wraps.
  task automatic send_message(input logic [28:0] id, output int items);
    logic [7:0]  service;
    logic [63:0] b;
    int          total;
    int          left;
    int          seq;
    int          flen;
    int          low;
    bit          trickle;
    items   = 0;
    service = $urandom_range(0, 1) ? SID_READ_DTC : 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) begin
      low = $urandom_range(1, 7);
      send_frame(id, 4'($urandom_range(low + 1, 15)),
                 with_head({PCI_SF, 4'(low)}, service, 8'($urandom()), 8'($urandom())));
      items = 1;
    end else begin
      // Most reports are short; a few fill the whole store.
      total   = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 65) : $urandom_range(8, 30);
      trickle = (total <= 30) && ($urandom_range(0, 9) == 0);
      send_frame(id, ($urandom_range(0, 3) == 0) ? 4'($urandom_range(9, 15)) : 4'd8,
                 with_head({PCI_FF, 4'h0}, 8'(total), service, 8'($urandom())));
      items = 1;
      left  = total - 6;
      seq   = 1;
      while (left > 0 && items < 70) begin
        if ($urandom_range(0, 19) == 0) send_noise(id);
        if (trickle) begin
          flen = $urandom_range(1, 3);
        end else begin
          case ($urandom_range(0, 4))
            0: flen = $urandom_range(0, 7);
            1: flen = $urandom_range(9, 15);
            default: flen = 8;
          endcase
        end
        b = {$urandom(), $urandom()};
        if ($urandom_range(0, 24) == 0) begin
          b[7:0] = {PCI_CF, 4'(seq + $urandom_range(1, 15))};
          send_frame(id, 4'(flen), b);
          items++;
          break;
        end
        b[7:0] = {PCI_CF, 4'(seq)};
        send_frame(id, 4'(flen), b);
        items++;
        left -= (flen > 8) ? 7 : ((flen > 0) ? flen - 1 : 0);
        seq = (seq + 1) % 16;
      end
    end
  endtask

  // One setting of the registers, then random traffic until the target number
  // of message frames has been sent. With with_hold set, the phase opens with
  // a burst of back-to-back frames while the receiver holds off, so the block
  // fills and stalls its input. The phase ends with the sender paused until
  // every result is back, which keeps the next register write idle.
  task automatic run_phase(input logic [28:0] id, input logic en, input int target,
                           input bit with_hold);
    int done_items;
    int n;
    int burst;
    write_regs(id, en);
    done_items = 0;
    burst      = with_hold ? 8 : 0;
    if (with_hold) hold_req <= hold_req + 1;
    while (done_items < target) begin
      fast_tx = (burst > 0) || ($urandom_range(0, 4) == 0);
      fast_rx = (burst == 0) && ($urandom_range(0, 4) == 0);
      if (burst > 0) burst--;
      case ($urandom_range(0, 9))
        0: send_noise(id);
        1: begin
          send_frame(id, 4'($urandom_range(4, 15)),
                     with_head(8'h03, SID_NEGATIVE, 8'($urandom()), 8'($urandom())));
          done_items++;
        end
        default: begin
          send_message(id, n);
          done_items += n;
        end
      endcase
    end
    drain();
  endtask

  // Receiver: before each result it waits a random number of cycles, or none
  // in fast stretches. A pending hold request instead keeps tready low for a
  // long, fixed stretch counted here.
  initial begin : result_sink
    int wait_cycles;
    int hold_done;
    hold_done = 0;
    out_tready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req != hold_done) begin
        hold_done = hold_req;
        out_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else begin
        wait_cycles = fast_rx ? 0 : $urandom_range(0, 13);
        if (wait_cycles > 0) begin
          out_tready <= 1'b0;
          repeat (wait_cycles) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin : stimulus
    logic [28:0] rid;
    int          k;
    rid = RESPONSE_ID_RST;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Out of reset the block is disabled: a valid frame for the reset
    // identifier must still be ignored.
    send_frame(rid, 4'd4, with_head(8'h03, 8'h62, 8'hF1, 8'h90));
    drain();
    write_regs(rid, 1'b1);

    // Directed frames: the ignore rules, a negative response, the shortest and
    // the longest single-frame reports, a summary item, the first-frame limits,
    // a full 64-byte report with padding, a sequence error and a stray
    // consecutive frame afterward.
    send_frame(rid ^ 29'h1, 4'd4, with_head(8'h03, 8'h62, 8'hF1, 8'h90));
    send_frame(rid, 4'd8, with_head(8'h00, 8'h62, 8'hF1, 8'h90));
    send_frame(rid, 4'd8, with_head(8'h08, 8'h62, 8'hF1, 8'h90));
    send_frame(rid, 4'd5, with_head(8'h05, 8'h62, 8'hF1, 8'h90));
    send_frame(rid, 4'd4, with_head(8'h03, SID_NEGATIVE, 8'h19, 8'h31));
    send_frame(rid, 4'd2, with_head(8'h01, SID_READ_DTC, 8'($urandom()), 8'($urandom())));
    send_frame(rid, 4'd8, with_head(8'h07, SID_READ_DTC, 8'h02, 8'hFF));
    send_frame(rid, 4'd3, with_head(8'h02, 8'h62, 8'($urandom()), 8'($urandom())));
    send_frame(rid, 4'd8, with_head({PCI_FF, 4'h0}, 8'h07, SID_READ_DTC, 8'h02));
    send_frame(rid, 4'd7, with_head({PCI_FF, 4'h0}, 8'h14, SID_READ_DTC, 8'h02));
    send_frame(rid, 4'd8, with_head({PCI_FF, 4'h0}, 8'h42, SID_READ_DTC, 8'h02));
    send_frame(rid, 4'd8, with_head({PCI_FF, 4'h0}, 8'h41, SID_READ_DTC, 8'h02));
    for (k = 1; k <= 9; k++)
      send_frame(rid, 4'd8, with_head({PCI_CF, 4'(k)}, 8'($urandom()), 8'($urandom()),
                                      8'($urandom())));
    send_frame(rid, 4'd8, with_head({PCI_FF, 4'h0}, 8'h14, 8'h62, 8'h01));
    send_frame(rid, 4'd8, with_head({PCI_CF, 4'h2}, 8'h00, 8'h00, 8'h00));
    send_frame(rid, 4'd8, with_head({PCI_CF, 4'h1}, 8'h00, 8'h00, 8'h00));
    drain();

    // Random phases across the identifier extremes, a random identifier, and
    // a short disabled stretch at the end.
    run_phase(rid, 1'b1, 90, 1'b1);
    run_phase(29'h1FFFFFFF, 1'b1, 90, 1'b0);
    run_phase(29'h0, 1'b1, 90, 1'b0);
    run_phase(29'($urandom()), 1'b1, 90, 1'b0);
    run_phase(29'($urandom()), 1'b0, 15, 1'b0);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && results_outstanding == 0) begin
      $display("PASS isotp_dtc_report_reassembler_top");
    end else begin
      $display("FAIL isotp_dtc_report_reassembler_top");
    end
    $finish;
  end

endmodule
